// ===== hdl/hsp_pkg.sv =====
package hsp_pkg;

  localparam int DEST_COUNT  = 16;
  localparam int DEST_W      = 4;
  localparam int POS_W       = 16;
  localparam int PERIOD_W    = 20;
  localparam int SPD_W       = 12;
  localparam int PROD_W      = DEST_W + SPD_W;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_W       = PERIOD_W;
  localparam int COIL_W      = 4;
  localparam int IN_TDATA_W  = 8;
  localparam int IN_TUSER_W  = 1;
  localparam int OUT_FIELD_W = COIL_W + 1 + 1 + POS_W + DEST_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  localparam logic [PERIOD_W-1:0] ELAPSED_MAX   = '1;
  localparam logic [POS_W-1:0]    POS_MAX       = '1;
  localparam logic [DEST_W-1:0]   DEST_LAST     = DEST_W'(DEST_COUNT - 1);
  localparam logic [PERIOD_W-1:0] PERIOD_RESET  = PERIOD_W'(488);
  localparam logic [SPD_W-1:0]    SPD_RESET     = SPD_W'(512);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP_PERIOD    = 1'b0,
    CFG_STEPS_PER_DEST = 1'b1
  } cfg_idx_t;

  typedef enum logic [0:0] {
    CMD_TICK = 1'b0,
    CMD_SET  = 1'b1
  } cmd_t;

  typedef struct packed {
    logic [DEST_W-1:0] destination_now;
    logic [POS_W-1:0]  position;
    logic              stepped;
    logic              moving;
    logic [COIL_W-1:0] coil_pattern;
  } hsp_result_t;

  // eight-phase half-step sequence, bit3 coil1 .. bit0 coil4
  function automatic logic [COIL_W-1:0] coil_of(input logic [2:0] phase);
    logic [COIL_W-1:0] pat;
    unique case (phase)
      3'd0: pat = 4'b1000;
      3'd1: pat = 4'b1100;
      3'd2: pat = 4'b0100;
      3'd3: pat = 4'b0110;
      3'd4: pat = 4'b0010;
      3'd5: pat = 4'b0011;
      3'd6: pat = 4'b0001;
      3'd7: pat = 4'b1001;
      default: pat = '0;
    endcase
    return pat;
  endfunction

endpackage

// ===== hdl/hsp_step_unit.sv =====
module hsp_step_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [hsp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hsp_pkg::CFG_W-1:0] cfg_wdata,
  input  logic                      fire,
  input  hsp_pkg::cmd_t             cmd,
  input  logic [hsp_pkg::DEST_W-1:0] destination,
  output hsp_pkg::hsp_result_t      result
);
  import hsp_pkg::*;

  logic [PERIOD_W-1:0] period_r;
  logic [SPD_W-1:0]    spd_r;
  logic [POS_W-1:0]    position_r, position_nxt;
  logic [POS_W-1:0]    target_r, target_nxt;
  logic [POS_W-1:0]    remaining_r, remaining_nxt;
  logic                moving_r, moving_nxt;
  logic [PERIOD_W-1:0] elapsed_r, elapsed_nxt;
  logic [DEST_W-1:0]   dest_r, dest_nxt;
  logic [COIL_W-1:0]   coil_r, coil_nxt;
  logic                stepped;

  logic [DEST_W-1:0]   dest_sat;
  logic [PROD_W-1:0]   prod;
  logic [POS_W-1:0]    target_new;
  logic [PERIOD_W-1:0] elapsed_inc;
  logic                going_up;

  always_comb begin
    dest_sat    = (destination > DEST_LAST) ? DEST_LAST : destination;
    prod        = PROD_W'(dest_sat) * PROD_W'(spd_r);
    target_new  = (prod > PROD_W'(POS_MAX)) ? POS_MAX : POS_W'(prod);
    elapsed_inc = (elapsed_r == ELAPSED_MAX) ? elapsed_r : elapsed_r + 1'b1;
    going_up    = target_r > position_r;

    position_nxt  = position_r;
    target_nxt    = target_r;
    remaining_nxt = remaining_r;
    moving_nxt    = moving_r;
    elapsed_nxt   = elapsed_r;
    dest_nxt      = dest_r;
    coil_nxt      = coil_r;
    stepped       = 1'b0;

    unique case (cmd)
      CMD_SET: begin
        target_nxt    = target_new;
        remaining_nxt = (target_new > position_r) ? target_new - position_r
                                                  : position_r - target_new;
        dest_nxt      = dest_sat;
        if (remaining_nxt != '0) begin
          moving_nxt = 1'b1;
        end
      end
      CMD_TICK: begin
        elapsed_nxt = elapsed_inc;
        if (remaining_r == '0) begin
          moving_nxt = 1'b0;
        end else begin
          moving_nxt = 1'b1;
          if (elapsed_inc >= period_r) begin
            position_nxt  = going_up ? position_r + 1'b1 : position_r - 1'b1;
            remaining_nxt = remaining_r - 1'b1;
            elapsed_nxt   = '0;
            coil_nxt      = coil_of(position_nxt[2:0]);
            stepped       = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r    <= PERIOD_RESET;
      spd_r       <= SPD_RESET;
      position_r  <= '0;
      target_r    <= '0;
      remaining_r <= '0;
      moving_r    <= 1'b0;
      elapsed_r   <= ELAPSED_MAX;
      dest_r      <= '0;
      coil_r      <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_STEP_PERIOD:    period_r <= cfg_wdata;
          CFG_STEPS_PER_DEST: spd_r    <= cfg_wdata[SPD_W-1:0];
          default: ;
        endcase
      end
      if (fire) begin
        position_r  <= position_nxt;
        target_r    <= target_nxt;
        remaining_r <= remaining_nxt;
        moving_r    <= moving_nxt;
        elapsed_r   <= elapsed_nxt;
        dest_r      <= dest_nxt;
        coil_r      <= coil_nxt;
      end
    end
  end

  always_comb begin
    result.coil_pattern    = coil_nxt;
    result.moving          = moving_nxt;
    result.stepped         = stepped;
    result.position        = position_nxt;
    result.destination_now = dest_nxt;
  end

endmodule

// ===== hdl/half_step_stepper_positioner.sv =====
// Half-step stepper positioner. Each input transfer is either a one
// microsecond tick (tuser 0) or a new destination slot (tuser 1), and each
// gives exactly one result transfer with the coil drive, the moving and
// stepped flags, the position and the last destination. An item enters an
// input register, is folded into the position state by one combinational
// update pass and lands in the result register; one item is taken every
// cycle while the result side keeps up. A destination sets the target
// to the destination slot times the slot spacing register; ticks then step
// one half step each time step_period_us microseconds have gone by, the
// first step after reset being immediate. Write the two registers only while
// no item is in flight.
module half_step_stepper_positioner (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // [3:0] destination
  input  logic [hsp_pkg::IN_TDATA_W-1:0] in_tdata,
  // [0] cmd
  input  logic [hsp_pkg::IN_TUSER_W-1:0] in_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [3:0] coil_pattern, [4] moving, [5] stepped, [21:6] position,
  // [25:22] destination_now
  output logic [hsp_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                          cfg_we,
  input  logic [hsp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hsp_pkg::CFG_W-1:0]     cfg_wdata
);
  import hsp_pkg::*;

  logic              in_valid_r;
  cmd_t              cmd_r;
  logic [DEST_W-1:0] dest_r;
  logic              out_valid_r;
  hsp_result_t       out_r;
  hsp_result_t       result;
  logic              advance;
  logic              fire;

  assign advance   = !out_valid_r || out_tready;
  assign fire      = in_valid_r && advance;
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      cmd_r  <= cmd_t'(in_tuser[0]);
      dest_r <= in_tdata[DEST_W-1:0];
    end
  end

  hsp_step_unit u_step (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .fire        (fire),
    .cmd         (cmd_r),
    .destination (dest_r),
    .result      (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(out_r);

endmodule

// ===== hdl/hsp_checker.sv =====
module hsp_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [hsp_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import hsp_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // nothing left over from before reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result shown after reset");

  // a step always drives some coil and counts as moving
  a_step_drive: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[5] |-> out_tdata[3:0] != '0 && out_tdata[4])
    else $error("step without coil drive or moving flag");

  // an input transfer with an empty output side comes out through the input and result registers
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !out_tvalid |=> ##1 out_tvalid)
    else $error("result missing after transfer");

endmodule

bind half_step_stepper_positioner hsp_checker u_hsp_checker (.*);
